### rtl/wcn_pkg.sv
package wcn_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_INT_BITS  = 8;

  localparam int GRID_W = 9;
  localparam logic [GRID_W-1:0] GRID_RESET = 9'd4;

  localparam int NOISE_W = 16;

  // only the low three bytes of the hash are ever used
  localparam int HASH_W = 24;
  localparam logic [31:0] HASH_K [3] = '{32'd73856093, 32'd19349663, 32'd83492791};

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  typedef enum logic [0:0] {
    REG_GRID_SIZE = 1'b0
  } reg_idx_t;

endpackage

### rtl/wcn_wrap.sv
module wcn_wrap #(
  parameter int FRAC_BITS = wcn_pkg::COORD_FRAC_BITS,
  parameter int INT_BITS  = wcn_pkg::COORD_INT_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic                                  vld_i,
  input  logic signed [FRAC_BITS+INT_BITS-1:0]  x_coord,
  input  logic signed [FRAC_BITS+INT_BITS-1:0]  y_coord,
  input  logic signed [FRAC_BITS+INT_BITS-1:0]  z_coord,
  input  logic [wcn_pkg::GRID_W-1:0]            grid,
  output logic                                  vld_o,
  output logic [wcn_pkg::GRID_W-1:0]            wrap_o [3][3],
  output logic [FRAC_BITS-1:0]                  frac_o [3]
);

  localparam int W  = FRAC_BITS + INT_BITS;
  localparam int GW = wcn_pkg::GRID_W;
  localparam int NS = INT_BITS;

  logic [NS+1:0]        vld_r;
  logic [W-1:0]         c_in [3];
  logic [INT_BITS-1:0]  base_c [3];
  logic [INT_BITS-1:0]  mag_c [3];
  logic [INT_BITS-1:0]  mag_r [NS][3];
  logic [GW-1:0]        rem_r [NS+1][3];
  logic [2:0]           neg_r [NS+1];
  logic [FRAC_BITS-1:0] frac_r [NS+1][3];
  logic [GW-1:0]        fold_c [3];
  logic [GW-1:0]        wrap_nxt [3][3];
  logic [GW-1:0]        wrap_r [3][3];
  logic [FRAC_BITS-1:0] frac_out_r [3];
  logic                 wrap_ok;

  // one restoring remainder bit
  function automatic logic [GW-1:0] rem_step(input logic [GW-1:0] rem, input logic b,
                                             input logic [GW-1:0] g);
    logic [GW:0] t;
    t = {rem, b};
    if (t >= {1'b0, g}) begin
      t = t - {1'b0, g};
    end
    return t[GW-1:0];
  endfunction

  assign c_in[0] = x_coord;
  assign c_in[1] = y_coord;
  assign c_in[2] = z_coord;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      base_c[a] = c_in[a][W-1:FRAC_BITS];
      mag_c[a]  = base_c[a][INT_BITS-1] ? (~base_c[a] + 1'b1) : base_c[a];
    end
  end

  // negative cells fold back into [0, g), then the two neighbors step around
  always_comb begin
    wrap_ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      fold_c[a] = (neg_r[NS][a] && (rem_r[NS][a] != '0)) ? (grid - rem_r[NS][a])
                                                          : rem_r[NS][a];
      wrap_nxt[a][0] = (fold_c[a] == '0) ? (grid - 1'b1) : (fold_c[a] - 1'b1);
      wrap_nxt[a][1] = fold_c[a];
      wrap_nxt[a][2] = (({1'b0, fold_c[a]} + 1'b1) == {1'b0, grid}) ? '0
                                                                   : (fold_c[a] + 1'b1);
      for (int o = 0; o < 3; o++) begin
        if (wrap_r[a][o] >= grid) begin
          wrap_ok = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        mag_r[0][a]  <= mag_c[a];
        neg_r[0][a]  <= base_c[a][INT_BITS-1];
        rem_r[0][a]  <= '0;
        frac_r[0][a] <= c_in[a][FRAC_BITS-1:0];
        for (int s = 0; s < NS; s++) begin
          neg_r[s+1][a]  <= neg_r[s][a];
          frac_r[s+1][a] <= frac_r[s][a];
          rem_r[s+1][a]  <= rem_step(rem_r[s][a], mag_r[s][a][NS-1-s], grid);
        end
        for (int s = 0; s < NS-1; s++) begin
          mag_r[s+1][a] <= mag_r[s][a];
        end
        frac_out_r[a] <= frac_r[NS][a];
        for (int o = 0; o < 3; o++) begin
          wrap_r[a][o] <= wrap_nxt[a][o];
        end
      end
    end
  end

  assign vld_o  = vld_r[NS+1];
  assign wrap_o = wrap_r;
  assign frac_o = frac_out_r;

  a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS+1] |-> wrap_ok)
    else $error("wrapped cell index not below grid size");

endmodule

### rtl/wcn_dist.sv
module wcn_dist #(
  parameter int FRAC_BITS = wcn_pkg::COORD_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        vld_i,
  input  logic [wcn_pkg::GRID_W-1:0]  wrap_i [3][3],
  input  logic [FRAC_BITS-1:0]        frac_i [3],
  output logic                        vld_o,
  output logic [2*FRAC_BITS+1:0]      min_o
);

  localparam int HW   = wcn_pkg::HASH_W;
  localparam int DW   = FRAC_BITS + 3;
  localparam int SQW  = 2*FRAC_BITS + 4;
  localparam int SUMW = 2*FRAC_BITS + 5;
  localparam int MW   = 2*FRAC_BITS + 2;
  localparam int JW   = FRAC_BITS + 1;
  localparam int NC   = 27;
  localparam int NL   = 32;

  localparam logic [SUMW-1:0] INIT = (SUMW'(9) << (2*FRAC_BITS)) >> 2;
  localparam logic signed [DW-1:0] ONE_S  = DW'(1) << FRAC_BITS;
  localparam logic signed [DW-1:0] HALF_S = DW'(1) << (FRAC_BITS-1);

  // jitter per hash byte: (2b-255)*3/1700 in coordinate units, rounded half away
  function automatic logic [256*JW-1:0] build_jit();
    logic [256*JW-1:0] tbl;
    longint t;
    longint mag;
    longint q;
    tbl = '0;
    for (int b = 0; b < 256; b++) begin
      t   = 2*b - 255;
      mag = (t < 0) ? -t : t;
      q   = (mag * 3 * (longint'(1) << FRAC_BITS) + 850) / 1700;
      if (t < 0) begin
        q = -q;
      end
      tbl[b*JW +: JW] = JW'(q);
    end
    return tbl;
  endfunction

  localparam logic [256*JW-1:0] JIT_TBL = build_jit();

  logic [8:0]                  vld_r;
  logic [HW-1:0]               prod_r [3][3];
  logic [FRAC_BITS-1:0]        frac_r [3];
  logic signed [DW-1:0]        delta_c [NC][3];
  logic signed [DW-1:0]        delta_r [NC][3];
  logic [SQW-1:0]              sq_c [NC][3];
  logic [SQW-1:0]              sq_r [NC][3];
  logic [SUMW-1:0]             sum_r [NC];
  logic [SUMW-1:0]             leaf_c [NL];
  logic [SUMW-1:0]             kid_a [1:NL-1];
  logic [SUMW-1:0]             kid_b [1:NL-1];
  logic [SUMW-1:0]             node_r [1:NL-1];

  // cell k = oz*9 + oy*3 + ox, offsets 0,1,2 stand for -1,0,+1
  always_comb begin
    logic [HW-1:0]        h;
    logic [7:0]           bt;
    logic signed [JW-1:0] jv;
    logic signed [DW-1:0] ct;
    logic signed [DW-1:0] fr;
    logic signed [2*DW-1:0] p;
    int                   o;
    for (int k = 0; k < NC; k++) begin
      h = prod_r[0][k % 3] ^ prod_r[1][(k / 3) % 3] ^ prod_r[2][k / 9];
      for (int a = 0; a < 3; a++) begin
        o  = (a == 0) ? (k % 3) : ((a == 1) ? ((k / 3) % 3) : (k / 9));
        bt = h[8*a +: 8];
        jv = signed'(JIT_TBL[bt*JW +: JW]);
        ct = (o == 0) ? (HALF_S - ONE_S) : ((o == 1) ? HALF_S : (HALF_S + ONE_S));
        fr = signed'(DW'(frac_r[a]));
        delta_c[k][a] = ct + DW'(jv) - fr;
        p  = delta_r[k][a] * delta_r[k][a];
        sq_c[k][a] = p[SQW-1:0];
      end
    end
  end

  // min tree, heap order: node i has children 2i and 2i+1, leaves past the last node
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      leaf_c[i] = sum_r[i];
    end
    for (int i = NC; i < NL; i++) begin
      leaf_c[i] = INIT;
    end
    for (int i = 1; i < NL/2; i++) begin
      kid_a[i] = node_r[2*i];
      kid_b[i] = node_r[2*i+1];
    end
    for (int i = NL/2; i < NL; i++) begin
      kid_a[i] = leaf_c[2*i-NL];
      kid_b[i] = leaf_c[2*i+1-NL];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[7:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        frac_r[a] <= frac_i[a];
        for (int o = 0; o < 3; o++) begin
          prod_r[a][o] <= HW'(wrap_i[a][o]) * wcn_pkg::HASH_K[a][HW-1:0];
        end
      end
      for (int k = 0; k < NC; k++) begin
        for (int a = 0; a < 3; a++) begin
          delta_r[k][a] <= delta_c[k][a];
          sq_r[k][a]    <= sq_c[k][a];
        end
        sum_r[k] <= SUMW'(sq_r[k][0]) + SUMW'(sq_r[k][1]) + SUMW'(sq_r[k][2]);
      end
      for (int i = 1; i < NL; i++) begin
        node_r[i] <= (kid_b[i] < kid_a[i]) ? kid_b[i] : kid_a[i];
      end
    end
  end

  assign vld_o = vld_r[8];
  assign min_o = node_r[1][MW-1:0];

  a_min_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[8] |-> (node_r[1] <= INIT))
    else $error("nearest squared distance above start value");

endmodule

### rtl/wcn_sqrt.sv
module wcn_sqrt #(
  parameter int FRAC_BITS = wcn_pkg::COORD_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         vld_i,
  input  logic [2*FRAC_BITS+1:0]       min_i,
  output logic                         vld_o,
  output logic [wcn_pkg::NOISE_W-1:0]  noise_o
);

  localparam int MW  = 2*FRAC_BITS + 2;
  localparam int NS  = FRAC_BITS + 1;
  localparam int RTW = FRAC_BITS + 1;
  localparam int RW  = FRAC_BITS + 3;
  localparam int NW  = wcn_pkg::NOISE_W;
  localparam logic [RTW-1:0] ONE = RTW'(1) << FRAC_BITS;

  typedef struct packed {
    logic [RW-1:0]  rem;
    logic [RTW-1:0] root;
  } sq_step_t;

  // one result bit of digit-by-digit square root
  function automatic sq_step_t sq_step(input logic [RW-1:0] rem, input logic [RTW-1:0] root,
                                       input logic [1:0] pair);
    sq_step_t      r;
    logic [RW+1:0] t;
    logic [RW+1:0] trial;
    t     = {rem, pair};
    trial = (RW+2)'({root, 2'b01});
    if (t >= trial) begin
      r.rem  = RW'(t - trial);
      r.root = {root[RTW-2:0], 1'b1};
    end else begin
      r.rem  = RW'(t);
      r.root = {root[RTW-2:0], 1'b0};
    end
    return r;
  endfunction

  logic [NS:1]     vld_r;
  sq_step_t        st_r [1:NS];
  logic [MW-1:0]   val_r [1:NS-1];
  logic [RTW-1:0]  v_c;
  logic [NW:0]     scaled_c;
  logic            out_vld_r;
  logic [NW-1:0]   noise_r;

  assign v_c = (st_r[NS].root < ONE) ? (ONE - st_r[NS].root) : '0;

  if (FRAC_BITS >= NW) begin : g_down
    assign scaled_c = (NW+1)'(v_c >> (FRAC_BITS - NW));
  end else begin : g_up
    assign scaled_c = (NW+1)'({v_c, {(NW-FRAC_BITS){1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[NS-1:1], vld_i};
      out_vld_r <= vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[1]  <= sq_step('0, '0, min_i[MW-1 -: 2]);
      val_r[1] <= min_i << 2;
      for (int s = 1; s < NS; s++) begin
        st_r[s+1] <= sq_step(st_r[s].rem, st_r[s].root, val_r[s][MW-1 -: 2]);
      end
      for (int s = 1; s < NS-1; s++) begin
        val_r[s+1] <= val_r[s] << 2;
      end
      noise_r <= scaled_c[NW] ? {NW{1'b1}} : scaled_c[NW-1:0];
    end
  end

  assign vld_o   = out_vld_r;
  assign noise_o = noise_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r) && $stable(out_vld_r))
    else $error("pipeline valids moved during stall");

endmodule

### rtl/worley_cellular_noise_3d_core.sv
// throughput: one point per cycle; the whole pipeline advances when the output register is free
// latency is set by the bit-serial cell-index remainder and the one-bit-per-stage square root
// reset: synchronous active-low rst_n clears all valid bits and sets grid_size to 4
module worley_cellular_noise_3d_core #(
  parameter int COORD_FRAC_BITS = wcn_pkg::COORD_FRAC_BITS,
  parameter int COORD_INT_BITS  = wcn_pkg::COORD_INT_BITS
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  // input channel
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic signed [COORD_FRAC_BITS+COORD_INT_BITS-1:0] in_x_coord,
  input  logic signed [COORD_FRAC_BITS+COORD_INT_BITS-1:0] in_y_coord,
  input  logic signed [COORD_FRAC_BITS+COORD_INT_BITS-1:0] in_z_coord,
  // result channel
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic [wcn_pkg::NOISE_W-1:0]                  out_noise_value,
  // register port
  input  logic                                         psel,
  input  logic                                         penable,
  input  logic                                         pwrite,
  input  logic [wcn_pkg::APB_ADDR_W-1:0]               paddr,
  input  logic [wcn_pkg::APB_DATA_W-1:0]               pwdata,
  output logic [wcn_pkg::APB_DATA_W-1:0]               prdata,
  output logic                                         pready
);

  localparam int GW = wcn_pkg::GRID_W;

  logic                       adv;
  logic                       wr_grid;
  logic [GW-1:0]              grid_r;
  logic [GW-1:0]              grid_eff;
  logic                       wrap_vld;
  logic [GW-1:0]              wrap_idx [3][3];
  logic [COORD_FRAC_BITS-1:0] wrap_frac [3];
  logic                       dist_vld;
  logic [2*COORD_FRAC_BITS+1:0] dist_min;

  // every stage shifts together; a held result stalls the whole pipe
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // register port: single word register, no wait states
  assign pready  = 1'b1;
  assign wr_grid = psel && penable && pwrite && (paddr[2] == wcn_pkg::REG_GRID_SIZE);
  assign prdata  = (paddr[2] == wcn_pkg::REG_GRID_SIZE)
                   ? {{(wcn_pkg::APB_DATA_W-GW){1'b0}}, grid_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= wcn_pkg::GRID_RESET;
    end else if (wr_grid) begin
      grid_r <= pwdata[GW-1:0];
    end
  end

  // a grid size of zero behaves as one
  assign grid_eff = (grid_r == '0) ? GW'(1) : grid_r;

  // cell floor and wrapped neighbor indices per axis
  wcn_wrap #(
    .FRAC_BITS (COORD_FRAC_BITS),
    .INT_BITS  (COORD_INT_BITS)
  ) u_wrap (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .vld_i   (in_valid),
    .x_coord (in_x_coord),
    .y_coord (in_y_coord),
    .z_coord (in_z_coord),
    .grid    (grid_eff),
    .vld_o   (wrap_vld),
    .wrap_o  (wrap_idx),
    .frac_o  (wrap_frac)
  );

  // hash, jitter, 27 squared distances and the min tree
  wcn_dist #(
    .FRAC_BITS (COORD_FRAC_BITS)
  ) u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .vld_i  (wrap_vld),
    .wrap_i (wrap_idx),
    .frac_i (wrap_frac),
    .vld_o  (dist_vld),
    .min_o  (dist_min)
  );

  // square root, one minus distance, scale and saturate, output register
  wcn_sqrt #(
    .FRAC_BITS (COORD_FRAC_BITS)
  ) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .vld_i   (dist_vld),
    .min_i   (dist_min),
    .vld_o   (out_valid),
    .noise_o (out_noise_value)
  );

  a_grid_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_grid |=> (grid_r == $past(pwdata[GW-1:0])))
    else $error("grid size register missed a write");

endmodule
